// ===== hdl/yrofw_pkg.sv =====
// ----------------------------------------------------------------------------
// yrofw_pkg
// Shared constants and types for the yaw rate offset window fit core.
// ----------------------------------------------------------------------------
package yrofw_pkg;

	localparam int WINDOW_DEPTH = 16384;
	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam int MW = 129;

	localparam logic signed [63:0] ACC_LIMIT = 64'sd2305843009213693952;

	typedef enum logic [2:0] {
		CFG_WINDOW_MIN = 3'd0,
		CFG_WINDOW_MAX = 3'd1,
		CFG_SPEED_THRESHOLD = 3'd2,
		CFG_USABLE_FRACTION = 3'd3,
		CFG_OUTLIER_LIMIT = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		WU_WAIT_HEADING = 2'd0,
		WU_COUNT = 2'd1,
		WU_DONE = 2'd2
	} warmup_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD,
		ST_RATE,
		ST_ACC,
		ST_Y,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_CHK0,
		ST_CHK1,
		ST_PMUL,
		ST_PADD,
		ST_DSETUP,
		ST_DIV,
		ST_FIT,
		ST_FINAL
	} state_t;

endpackage

// ===== hdl/yaw_rate_offset_window_fit_core.sv =====
// ----------------------------------------------------------------------------
// yaw_rate_offset_window_fit_core
// Gyro yaw rate offset from a least-squares slope fit over a sample window.
// ----------------------------------------------------------------------------
//  channel | signals                                        | direction
//  in      | in_valid/in_ready, time_us .. stop_offset      | request in
//  out     | out_valid/out_ready, offset_out, enabled, est. | request out
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data       | register write
//
//  a request without a fit goes from idle straight to the final state; a fit
//  walks the window through one shared 33x33 multiplier (usable samples also
//  pass P0..P3), then forms wide products and runs a restoring division
//  no clearing pass after reset; cfg_ready is always high
//  in_ready is high only in idle; a result waiting on out_ready does not block
//  acceptance, but the next request finishes only once the output is free
// ----------------------------------------------------------------------------
module yaw_rate_offset_window_fit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] time_us,
	input  logic [31:0] yaw_rate,
	input  logic [31:0] heading,
	input  logic        heading_valid,
	input  logic [31:0] speed,
	input  logic [31:0] stop_offset,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] offset_out,
	output logic        enabled,
	output logic        estimated,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import yrofw_pkg::*;

	state_t state_q, state_n;

	// configuration
	logic [14:0] wmin_q, wmax_q;
	logic [31:0] thr_q, lim_q;
	logic [16:0] frac_q;

	// persistent state
	logic [FW-1:0] fill_q;
	logic [AW-1:0] wp_q;
	warmup_t       phase_q;
	logic [14:0]   wcount_q;
	logic [31:0]   offset_q;
	logic          en_q, est_q;
	logic [31:0]   stop_q;

	// output register
	logic          ovalid_q;
	logic [31:0]   ooff_q;
	logic          oen_q, oest_q;

	// sample memory
	logic [MW-1:0] mem [WINDOW_DEPTH];
	logic [MW-1:0] rd_q;
	logic [AW-1:0] pos_q;

	// walk
	logic [FW-1:0] idx_q;
	logic [31:0]   tprev_q, t0_q, x_q;
	logic signed [63:0] acc_q;
	logic [63:0]   ay_q;
	logic          yneg_q;
	logic [14:0]   n_q;
	logic [63:0]   sx_q;
	logic [127:0]  sy_q, sxx_q, sxy_q, term_q;

	// wide products and division
	logic [1:0]    psel_q, pi_q;
	logic          pj_q;
	logic [127:0]  wacc_q, num_q, den_q;
	logic [127:0]  dvd_q, dvs_q, r_q, quo_q;
	logic [6:0]    k_q;
	logic          neg_q;

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_q;

	// sample fields
	logic [31:0] s_time, s_rate, s_head, s_speed;
	logic        s_valid, usable_c;
	assign s_time  = rd_q[31:0];
	assign s_rate  = rd_q[63:32];
	assign s_head  = rd_q[95:64];
	assign s_speed = rd_q[127:96];
	assign s_valid = rd_q[128];
	assign usable_c = s_valid && ($signed({s_speed[31], s_speed}) > $signed({1'b0, thr_q}));

	logic in_acc;
	assign in_acc = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// accept-time values
	logic [14:0]   cur_c;
	logic [FW-1:0] curc_c, fill_n;
	logic [AW-1:0] wp_n;
	warmup_t       phase_n;
	logic [14:0]   wcount_n;
	logic          new_usable;
	logic [FW:0]   start_sum;
	logic [AW-1:0] start_pos;

	always_comb begin
		cur_c = en_q ? wmax_q : wmin_q;
		if (cur_c == 15'd0) begin
			curc_c = FW'(1);
		end else if ({{(32-15){1'b0}}, cur_c} > WINDOW_DEPTH) begin
			curc_c = FW'(WINDOW_DEPTH);
		end else begin
			curc_c = FW'(cur_c);
		end
		fill_n = (fill_q < curc_c) ? fill_q + FW'(1) : curc_c;
		wp_n = (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + AW'(1);
		phase_n = phase_q;
		wcount_n = wcount_q;
		unique case (phase_q)
			WU_WAIT_HEADING: begin
				if (heading_valid) phase_n = WU_COUNT;
			end
			WU_COUNT: begin
				if (wcount_q < wmin_q) wcount_n = wcount_q + 15'd1;
				else phase_n = WU_DONE;
			end
			default: ;
		endcase
		new_usable = heading_valid && ($signed({speed[31], speed}) > $signed({1'b0, thr_q}));
		start_sum = {1'b0, FW'(wp_n)} + (FW+1)'(WINDOW_DEPTH) - {1'b0, fill_n};
		if (start_sum >= (FW+1)'(WINDOW_DEPTH)) begin
			start_pos = AW'(start_sum - (FW+1)'(WINDOW_DEPTH));
		end else begin
			start_pos = AW'(start_sum);
		end
	end

	// walk arithmetic
	logic signed [63:0] prod_cl, acc_cl;
	logic signed [64:0] acc_sum;
	logic [31:0]        dt_c, t0_c, x_c;
	logic signed [63:0] y_c;
	logic               last_c, adv_c;

	always_comb begin
		dt_c = s_time - tprev_q;
		if (mul_q > 66'(ACC_LIMIT)) prod_cl = ACC_LIMIT;
		else if (mul_q < -66'(ACC_LIMIT)) prod_cl = -ACC_LIMIT;
		else prod_cl = mul_q[63:0];
		acc_sum = 65'(acc_q) + 65'(prod_cl);
		if (acc_sum > 65'(ACC_LIMIT)) acc_cl = ACC_LIMIT;
		else if (acc_sum < -65'(ACC_LIMIT)) acc_cl = -ACC_LIMIT;
		else acc_cl = acc_sum[63:0];
		t0_c = (n_q == 15'd0) ? s_time : t0_q;
		x_c = s_time - t0_c;
		y_c = acc_q - mul_q[63:0];
		last_c = (idx_q == fill_q - FW'(1));
		adv_c = (state_q == ST_P3) || (state_q == ST_Y && !usable_c);
	end

	// wide product operands
	logic [127:0] wa_c;
	logic [63:0]  wb_c;
	logic [31:0]  wa_chunk, wb_chunk;
	logic [127:0] wpart_c;
	logic [7:0]   wsh_c;

	always_comb begin
		case (psel_q)
			2'd0: begin wa_c = sxy_q; wb_c = {49'b0, n_q}; end
			2'd1: begin wa_c = sy_q; wb_c = sx_q; end
			2'd2: begin wa_c = sxx_q; wb_c = {49'b0, n_q}; end
			default: begin wa_c = {64'b0, sx_q}; wb_c = sx_q; end
		endcase
		wa_chunk = wa_c[32*pi_q +: 32];
		wb_chunk = wb_c[32*pj_q +: 32];
		wsh_c = {({1'b0, pi_q} + {2'b0, pj_q}), 5'b0};
		wpart_c = {64'b0, mul_q[63:0]} << wsh_c;
	end

	// division step
	logic [127:0] r_sh;
	logic         ge_c;
	assign r_sh = {r_q[126:0], dvd_q[127]};
	assign ge_c = (r_sh >= dvs_q);

	// fit result
	logic [31:0] fit_off;
	always_comb begin
		if (quo_q > 128'd2147483648) begin
			fit_off = neg_q ? 32'h7FFF_FFFF : 32'h8000_0000;
		end else if (neg_q) begin
			fit_off = (quo_q[31:0] == 32'h8000_0000) ? 32'h7FFF_FFFF : quo_q[31:0];
		end else begin
			fit_off = -quo_q[31:0];
		end
	end

	// final offset
	logic [31:0]        off_c, fin_off;
	logic signed [32:0] d_c;
	logic [32:0]        dabs_c;
	always_comb begin
		off_c = en_q ? offset_q : stop_q;
		d_c = $signed({off_c[31], off_c}) - $signed({stop_q[31], stop_q});
		dabs_c = d_c[32] ? 33'(-d_c) : 33'(d_c);
		fin_off = (dabs_c > {1'b0, lim_q}) ? stop_q : off_c;
	end

	logic out_free;
	assign out_free = !ovalid_q || out_ready;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_n = (phase_n == WU_DONE && new_usable) ? ST_RD : ST_FINAL;
			end
			ST_RD: state_n = ST_RATE;
			ST_RATE: state_n = ST_ACC;
			ST_ACC: state_n = ST_Y;
			ST_Y: begin
				if (usable_c) state_n = ST_P0;
				else state_n = last_c ? ST_CHK0 : ST_RD;
			end
			ST_P0: state_n = ST_P1;
			ST_P1: state_n = ST_P2;
			ST_P2: state_n = ST_P3;
			ST_P3: state_n = last_c ? ST_CHK0 : ST_RD;
			ST_CHK0: state_n = ST_CHK1;
			ST_CHK1: begin
				state_n = ({2'b0, n_q, 16'b0} > {1'b0, mul_q[31:0]}) ? ST_PMUL : ST_FINAL;
			end
			ST_PMUL: state_n = ST_PADD;
			ST_PADD: begin
				if (pi_q == 2'd3 && pj_q && psel_q == 2'd3) state_n = ST_DSETUP;
				else state_n = ST_PMUL;
			end
			ST_DSETUP: state_n = (den_q[127] || den_q == '0) ? ST_FINAL : ST_DIV;
			ST_DIV: state_n = (k_q == 7'd0) ? ST_FIT : ST_DIV;
			ST_FIT: state_n = ST_FINAL;
			ST_FINAL: state_n = out_free ? ST_IDLE : ST_FINAL;
			default: state_n = ST_IDLE;
		endcase
	end

	// outputs and multiplier operands
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_RATE: begin
				mul_a = {s_rate[31], s_rate};
				mul_b = {1'b0, dt_c};
			end
			ST_ACC: begin
				mul_a = {s_head[31], s_head};
				mul_b = 33'sd1000000;
			end
			ST_P0: begin mul_a = {1'b0, x_q}; mul_b = {1'b0, ay_q[31:0]}; end
			ST_P1: begin mul_a = {1'b0, x_q}; mul_b = {1'b0, ay_q[63:32]}; end
			ST_P2: begin mul_a = {1'b0, x_q}; mul_b = {1'b0, x_q}; end
			ST_CHK0: begin
				mul_a = {{(33-FW){1'b0}}, fill_q};
				mul_b = {16'b0, frac_q};
			end
			ST_PMUL: begin mul_a = {1'b0, wa_chunk}; mul_b = {1'b0, wb_chunk}; end
			default: ;
		endcase
	end

	assign out_valid  = ovalid_q;
	assign offset_out = ooff_q;
	assign enabled    = oen_q;
	assign estimated  = oest_q;

	// sample memory
	always_ff @(posedge clk) begin
		if (in_acc) mem[wp_q] <= {heading_valid, speed, heading, yaw_rate, time_us};
		rd_q <= mem[pos_q];
	end

	// multiplier and datapath
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					stop_q <= stop_offset;
					pos_q <= start_pos;
					idx_q <= '0;
					acc_q <= '0;
					n_q <= '0;
					sx_q <= '0;
					sy_q <= '0;
					sxx_q <= '0;
					sxy_q <= '0;
				end
			end
			ST_ACC: begin
				if (idx_q != '0) acc_q <= acc_cl;
			end
			ST_Y: begin
				if (usable_c) begin
					t0_q <= t0_c;
					x_q <= x_c;
					yneg_q <= y_c[63];
					ay_q <= y_c[63] ? 64'(-y_c) : 64'(y_c);
					sy_q <= sy_q + {{64{y_c[63]}}, y_c};
					sx_q <= sx_q + {32'b0, x_c};
					n_q <= n_q + 15'd1;
				end
			end
			ST_P1: term_q <= {64'b0, mul_q[63:0]};
			ST_P2: term_q <= term_q + {32'b0, mul_q[63:0], 32'b0};
			ST_P3: begin
				sxy_q <= yneg_q ? sxy_q - term_q : sxy_q + term_q;
				sxx_q <= sxx_q + {64'b0, mul_q[63:0]};
			end
			ST_CHK1: begin
				psel_q <= 2'd0;
				pi_q <= 2'd0;
				pj_q <= 1'b0;
				wacc_q <= '0;
			end
			ST_PADD: begin
				if (pi_q == 2'd3 && pj_q) begin
					case (psel_q)
						2'd0: num_q <= wacc_q + wpart_c;
						2'd1: num_q <= num_q - (wacc_q + wpart_c);
						2'd2: den_q <= wacc_q + wpart_c;
						default: den_q <= den_q - (wacc_q + wpart_c);
					endcase
					wacc_q <= '0;
					psel_q <= psel_q + 2'd1;
				end else begin
					wacc_q <= wacc_q + wpart_c;
				end
				pj_q <= ~pj_q;
				if (pj_q) pi_q <= pi_q + 2'd1;
			end
			ST_DSETUP: begin
				neg_q <= num_q[127];
				dvd_q <= ((num_q[127] ? -num_q : num_q) << 1) + den_q;
				dvs_q <= den_q << 1;
				r_q <= '0;
				quo_q <= '0;
				k_q <= 7'd127;
			end
			ST_DIV: begin
				dvd_q <= dvd_q << 1;
				r_q <= ge_c ? r_sh - dvs_q : r_sh;
				quo_q <= {quo_q[126:0], ge_c};
				k_q <= k_q - 7'd1;
			end
			default: ;
		endcase
		if (adv_c) begin
			tprev_q <= s_time;
			pos_q <= (pos_q == AW'(WINDOW_DEPTH - 1)) ? '0 : pos_q + AW'(1);
			idx_q <= idx_q + FW'(1);
		end
		if (state_q == ST_FINAL && out_free) begin
			ooff_q <= fin_off;
			oen_q <= en_q;
			oest_q <= est_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wmin_q <= 15'd1500;
			wmax_q <= 15'd15000;
			thr_q <= 32'd182190;
			frac_q <= 17'd1638;
			lim_q <= 32'd33554;
			fill_q <= '0;
			wp_q <= '0;
			phase_q <= WU_WAIT_HEADING;
			wcount_q <= '0;
			offset_q <= '0;
			en_q <= 1'b0;
			est_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_WINDOW_MIN: wmin_q <= cfg_data[14:0];
					CFG_WINDOW_MAX: wmax_q <= cfg_data[14:0];
					CFG_SPEED_THRESHOLD: thr_q <= cfg_data;
					CFG_USABLE_FRACTION: frac_q <= cfg_data[16:0];
					CFG_OUTLIER_LIMIT: lim_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				fill_q <= fill_n;
				wp_q <= wp_n;
				phase_q <= phase_n;
				wcount_q <= wcount_n;
			end
			if (state_q == ST_FIT) begin
				offset_q <= fit_off;
				en_q <= 1'b1;
				est_q <= 1'b1;
			end
			if (state_q == ST_FINAL && out_free) begin
				offset_q <= fin_off;
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule
